[rtl/sjs_pkg.sv]
// ============================================================================
// sjs_pkg
// Shared types and constants for the sorted-table jump search block.
// ============================================================================
package sjs_pkg;

    localparam int CNT_W      = 11;  // entry_count register
    localparam int IDX_W      = 10;  // entry_index / position
    localparam int VAL_W      = 32;  // table entry / sought value
    localparam int PTR_W      = 12;  // search pointer, holds count - 1 + step
    localparam int ROOT_W     = 6;   // floor(sqrt(2047)) = 45
    localparam int ROOT_BIT_W = 3;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_LOAD,
        DP_CAPTURE,
        DP_SQRT,
        DP_START,
        DP_JUMP,
        DP_SETUP,
        DP_SCAN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic sqrt_last;
        logic lt;
        logic next_in;
        logic eq;
        logic at_hi;
    } t_dp_stat;

endpackage

[rtl/sjs_ram.sv]
// ============================================================================
// sjs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module sjs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sjs_datapath.sv]
// ============================================================================
// sjs_datapath
// Table memory, square root unit, jump/scan pointers and result register.
// ============================================================================
module sjs_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sjs_pkg::CNT_W-1:0]              i_cfg_data,
    input  logic [sjs_pkg::IDX_W-1:0]              i_entry_index,
    input  logic signed [sjs_pkg::VAL_W-1:0]       i_item_value,
    input  sjs_pkg::t_dp_cmd                       i_cmd,
    output sjs_pkg::t_dp_stat                      o_stat,
    output logic                                   o_found,
    output logic [sjs_pkg::IDX_W-1:0]              o_position
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = sjs_pkg::CNT_W;
    localparam int PW = sjs_pkg::PTR_W;
    localparam int RW = sjs_pkg::ROOT_W;
    localparam int BW = sjs_pkg::ROOT_BIT_W;
    localparam int IW = sjs_pkg::IDX_W;
    localparam int VW = sjs_pkg::VAL_W;

    logic [CW-1:0]        r_entry_count;
    logic [CW-1:0]        r_count;
    logic signed [VW-1:0] r_val;
    logic [RW-1:0]        r_root;
    logic [BW-1:0]        r_bit;
    logic [PW-1:0]        r_ptr;
    logic [PW-1:0]        r_hi;
    logic                 r_hit;
    logic                 r_found;
    logic [IW-1:0]        r_position;

    logic [CW-1:0]        n_count;
    logic [RW-1:0]        n_trial;
    logic [2*RW-1:0]      n_trial_sq;
    logic [PW-1:0]        n_step;
    logic [PW-1:0]        n_jump;
    logic [PW-1:0]        n_lo;
    logic [PW-1:0]        n_hi;
    logic [PW-1:0]        n_count_ext;
    logic [PW-1:0]        n_raddr;
    logic                 n_we;
    logic signed [VW-1:0] n_rdata;

    assign n_count = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                              : r_entry_count;
    assign n_trial     = r_root | (RW'(1) << r_bit);
    assign n_trial_sq  = n_trial * n_trial;
    assign n_step      = PW'(r_root);
    assign n_jump      = r_ptr + n_step;
    assign n_count_ext = PW'(r_count);
    assign n_lo        = (r_ptr >= n_step) ? r_ptr - n_step : '0;
    assign n_hi        = (r_ptr < n_count_ext) ? r_ptr : n_count_ext - PW'(1);

    assign n_we = (i_cmd.op == sjs_pkg::DP_LOAD)
                  && (32'(i_entry_index) < 32'(TABLE_DEPTH));

    always_comb begin
        case (i_cmd.op)
            sjs_pkg::DP_START: n_raddr = '0;
            sjs_pkg::DP_JUMP:  n_raddr = n_jump;
            sjs_pkg::DP_SETUP: n_raddr = n_lo;
            sjs_pkg::DP_SCAN:  n_raddr = r_ptr + PW'(1);
            default:           n_raddr = r_ptr;
        endcase
    end

    sjs_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_item_value),
        .i_raddr (AW'(n_raddr)),
        .o_rdata (n_rdata)
    );

    assign o_stat.cnt_zero  = (r_entry_count == '0);
    assign o_stat.sqrt_last = (r_bit == '0);
    assign o_stat.lt        = (n_rdata < r_val);
    assign o_stat.next_in   = (n_jump < n_count_ext);
    assign o_stat.eq        = (n_rdata == r_val);
    assign o_stat.at_hi     = (r_ptr == r_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            sjs_pkg::DP_CAPTURE: begin
                r_count <= n_count;
                r_val   <= i_item_value;
                r_root  <= '0;
                r_bit   <= BW'(RW - 1);
                r_hit   <= 1'b0;
            end
            sjs_pkg::DP_SQRT: begin
                if (32'(n_trial_sq) <= 32'(r_count)) begin
                    r_root <= n_trial;
                end
                r_bit <= r_bit - BW'(1);
            end
            sjs_pkg::DP_START: begin
                r_ptr <= '0;
            end
            sjs_pkg::DP_JUMP: begin
                if (o_stat.lt) begin
                    r_ptr <= n_jump;
                end
            end
            sjs_pkg::DP_SETUP: begin
                r_ptr <= n_lo;
                r_hi  <= n_hi;
            end
            sjs_pkg::DP_SCAN: begin
                if (o_stat.eq) begin
                    r_hit <= 1'b1;
                end else if (!o_stat.at_hi) begin
                    r_ptr <= r_ptr + PW'(1);
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_found    <= r_hit;
            r_position <= r_hit ? r_ptr[IW-1:0] : '0;
        end
    end

    assign o_found    = r_found;
    assign o_position = r_position;

endmodule

[rtl/sjs_ctrl.sv]
// ============================================================================
// sjs_ctrl
// Sequencer for load and search words; owns the handshakes.
// ============================================================================
module sjs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sjs_pkg::t_dp_stat i_stat,
    output sjs_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQRT,
        S_START,
        S_JUMP,
        S_SETUP,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_free;

    assign n_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd.op        = sjs_pkg::DP_IDLE;
        o_cmd.out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == sjs_pkg::CMD_SEARCH) begin
                        o_cmd.op = sjs_pkg::DP_CAPTURE;
                        n_state  = i_stat.cnt_zero ? S_DONE : S_SQRT;
                    end else begin
                        o_cmd.op = sjs_pkg::DP_LOAD;
                    end
                end
            end
            S_SQRT: begin
                o_cmd.op = sjs_pkg::DP_SQRT;
                if (i_stat.sqrt_last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.op = sjs_pkg::DP_START;
                n_state  = S_JUMP;
            end
            S_JUMP: begin
                o_cmd.op = sjs_pkg::DP_JUMP;
                if (!(i_stat.lt && i_stat.next_in)) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.op = sjs_pkg::DP_SETUP;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = sjs_pkg::DP_SCAN;
                if (i_stat.eq || i_stat.at_hi) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (n_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/sorted_table_jump_search_top.sv]
// ============================================================================
// sorted_table_jump_search_top
// Jump search over a software-loaded table of sorted signed 32-bit entries.
// ============================================================================
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  input    | i_in_valid / o_in_ready    | i_command, i_entry_index, i_item_value
//  output   | o_out_valid / i_out_ready  | o_found, o_position
//  config   | i_cfg_we                   | i_cfg_data (entry_count)
//
//  Load word: written to the table in the accept cycle, next word taken at once.
//  Search word: a capture step, 6 square-root steps, a start step, the jump
//  steps (one per jump, up to count/step rounded up), a setup step, the scan
//  steps (one per scanned entry, up to step+1) and a done step that loads the
//  output register. A result waiting on i_out_ready stalls only the next
//  search, in its done step. Reset clears entry_count and the handshake state;
//  table contents are undefined until loaded.
//
module sorted_table_jump_search_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sjs_pkg::CNT_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_command,
    input  logic [sjs_pkg::IDX_W-1:0]           i_entry_index,
    input  logic signed [sjs_pkg::VAL_W-1:0]    i_item_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [sjs_pkg::IDX_W-1:0]           o_position
);

    sjs_pkg::t_dp_cmd  n_cmd;
    sjs_pkg::t_dp_stat n_stat;

    sjs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (n_stat),
        .o_cmd       (n_cmd)
    );

    sjs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_item_value  (i_item_value),
        .i_cmd         (n_cmd),
        .o_stat        (n_stat),
        .o_found       (o_found),
        .o_position    (o_position)
    );

endmodule

[tb/sv/tb_sorted_table_jump_search_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_sorted_table_jump_search_top
// Self-checking bench for the sorted-table jump search block.
// ----------------------------------------------------------------------------
// A short directed table goes first: the empty table, the extreme values,
// duplicates, misses, an unsorted entry and the one-entry table. Random
// phases follow. Each phase sets the entry count while the block is idle,
// loads a sorted table of random spread and then searches it, mostly for
// hits and near misses, with a little stray load traffic mixed in. The first
// phases fill the whole table and then use an over-range count. Search words
// are scored against a local jump search over a shadow copy of the table,
// some directed ones against a typed result instead. Both handshakes see
// random gaps, and one long output hold-off backs the block up.
// ============================================================================
module tb_sorted_table_jump_search_top;

    localparam int          CNT_W        = sjs_pkg::CNT_W;
    localparam int          IDX_W        = sjs_pkg::IDX_W;
    localparam int          VAL_W        = sjs_pkg::VAL_W;
    localparam int          TABLE_DEPTH  = 1024;
    localparam int          ITEMS        = 1900;
    localparam int          IDLE_WAIT    = 100;
    localparam int          END_WAIT     = 200;
    localparam int          HOLD_AT      = 150;
    localparam int          HOLD_CYCLES  = 400;
    localparam int unsigned LIMIT_CYCLES = 5000000;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } t_result_word;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_SEARCH,
        ROW_SEARCH_EXP
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] data;
        logic             exp_found;
        logic [IDX_W-1:0] exp_pos;
    } t_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CNT_W-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_command;
    logic [IDX_W-1:0]        i_entry_index;
    logic signed [VAL_W-1:0] i_item_value;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_found;
    logic [IDX_W-1:0]        o_position;

    logic signed [VAL_W-1:0] entries_q [TABLE_DEPTH];
    logic [CNT_W-1:0]        entry_count_q;
    t_result_word            pending_results [$];
    int                      errors = 0;
    int                      results_seen = 0;
    int unsigned             cycle_count = 0;
    int                      tx_calm = 0;
    int                      rx_calm = 0;

    sorted_table_jump_search_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_entry_index(i_entry_index),
        .i_item_value (i_item_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_found      (o_found),
        .o_position   (o_position)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones, and now and then a calm stretch.
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 3) begin
            calm = $urandom_range(50, 200);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_result_word jump_search_result(input logic signed [VAL_W-1:0] key);
        t_result_word res;
        int unsigned  n, step, stop, lo, hi, i;
        res = '0;
        n = entry_count_q;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        if (n == 0) return res;
        step = 0;
        while ((step + 1) * (step + 1) <= n) step++;
        stop = 0;
        while (stop < n && entries_q[stop] < key) stop += step;
        lo = (stop >= step) ? stop - step : 0;
        hi = (stop < n) ? stop : n - 1;
        for (i = lo; i <= hi; i++) begin
            if (entries_q[i] == key) begin
                res.found    = 1'b1;
                res.position = i[IDX_W-1:0];
                break;
            end
        end
        return res;
    endfunction

    task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input logic typed,
                             input t_result_word typed_res);
        int gap;
        gap = pick_gap(tx_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_entry_index <= idx;
        i_item_value  <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (cmd == sjs_pkg::CMD_LOAD)
            entries_q[idx] = val;
        else if (typed)
            pending_results.push_back(typed_res);
        else
            pending_results.push_back(jump_search_result(val));
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Loads leave no result behind, so give the block its search latency
    // before touching the count.
    task automatic write_count(input logic [CNT_W-1:0] value);
        idle_input();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_data    <= value;
        entry_count_q  = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, got found %0d position %0d",
                         $time, o_found, o_position);
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found) begin
                    errors++;
                    $display("%0t: found mismatch, expected %0d, got %0d",
                             $time, want.found, o_found);
                end
                if (o_position !== want.position) begin
                    errors++;
                    $display("%0t: position mismatch, expected %0d, got %0d",
                             $time, want.position, o_position);
                end
            end
        end
    end

    // Output side, with one long hold-off to back the block up.
    initial begin
        int  stall_left;
        bit  held;
        i_out_ready = 1'b0;
        stall_left  = 0;
        held        = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AT) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap(rx_calm) : 0;
            end
        end
    end

    initial begin
        t_row         dir_rows [$];
        t_row         row;
        t_result_word typed_res;
        t_result_word none;
        int           phase, n, cnt, live, searches, k, r, i, pick;
        int unsigned  random_words;
        longint       acc, span;
        logic [VAL_W-1:0] key;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_command     = sjs_pkg::CMD_LOAD;
        i_entry_index = '0;
        i_item_value  = '0;
        entry_count_q = '0;
        none          = '0;
        random_words  = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows = '{
            '{ROW_SEARCH_EXP, 10'd0,    32'd0,          1'b0, 10'd0},
            '{ROW_SEARCH_EXP, 10'd1023, VAL_MIN,        1'b0, 10'd0},
            '{ROW_LOAD,       10'd0,    VAL_MIN,        1'b0, 10'd0},
            '{ROW_LOAD,       10'd1,    -32'sd5,        1'b0, 10'd0},
            '{ROW_LOAD,       10'd2,    32'd0,          1'b0, 10'd0},
            '{ROW_LOAD,       10'd3,    32'd7,          1'b0, 10'd0},
            '{ROW_LOAD,       10'd4,    32'd7,          1'b0, 10'd0},
            '{ROW_LOAD,       10'd5,    32'd100,        1'b0, 10'd0},
            '{ROW_LOAD,       10'd6,    32'd1000,       1'b0, 10'd0},
            '{ROW_LOAD,       10'd7,    VAL_MAX,        1'b0, 10'd0},
            '{ROW_LOAD,       10'd8,    VAL_MAX,        1'b0, 10'd0},
            '{ROW_LOAD,       10'd1023, 32'h5555_AAAA,  1'b0, 10'd0},
            '{ROW_CFG,        10'd0,    32'd9,          1'b0, 10'd0},
            '{ROW_SEARCH_EXP, 10'd0,    VAL_MIN,        1'b1, 10'd0},
            '{ROW_SEARCH,     10'd0,    VAL_MAX,        1'b0, 10'd0},
            '{ROW_SEARCH,     10'd0,    32'd7,          1'b0, 10'd0},
            '{ROW_SEARCH,     10'd0,    32'd6,          1'b0, 10'd0},
            '{ROW_SEARCH,     10'd0,    -32'sd6,        1'b0, 10'd0},
            '{ROW_SEARCH,     10'd0,    32'd100,        1'b0, 10'd0},
            '{ROW_SEARCH,     10'd0,    32'd0,          1'b0, 10'd0},
            '{ROW_LOAD,       10'd2,    32'd2000,       1'b0, 10'd0},
            '{ROW_SEARCH,     10'd0,    32'd1000,       1'b0, 10'd0},
            '{ROW_SEARCH,     10'd0,    32'd2000,       1'b0, 10'd0},
            '{ROW_CFG,        10'd0,    32'd1,          1'b0, 10'd0},
            '{ROW_SEARCH_EXP, 10'd0,    VAL_MIN,        1'b1, 10'd0},
            '{ROW_SEARCH,     10'd0,    32'd5,          1'b0, 10'd0},
            '{ROW_CFG,        10'd0,    32'd0,          1'b0, 10'd0},
            '{ROW_SEARCH_EXP, 10'd0,    VAL_MAX,        1'b0, 10'd0}
        };

        foreach (dir_rows[j]) begin
            row = dir_rows[j];
            typed_res.found    = row.exp_found;
            typed_res.position = row.exp_pos;
            case (row.kind)
                ROW_CFG: begin
                    write_count(row.data[CNT_W-1:0]);
                end
                ROW_LOAD: begin
                    send_word(sjs_pkg::CMD_LOAD, row.index, row.data, 1'b0, none);
                end
                ROW_SEARCH: begin
                    send_word(sjs_pkg::CMD_SEARCH, row.index, row.data, 1'b0, none);
                end
                default: begin
                    send_word(sjs_pkg::CMD_SEARCH, row.index, row.data, 1'b1, typed_res);
                end
            endcase
        end

        // Phase 0 fills the whole table; after that every entry is defined.
        for (phase = 0; random_words < ITEMS; phase++) begin
            if (phase == 0) begin
                cnt = TABLE_DEPTH;
                n   = TABLE_DEPTH;
            end else if (phase == 1) begin
                cnt = 2047;
                n   = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                r = $urandom_range(0, 3);
                case (r)
                    0:       cnt = 0;
                    1:       cnt = TABLE_DEPTH;
                    2:       cnt = $urandom_range(TABLE_DEPTH + 1, 2047);
                    default: cnt = $urandom_range(65, TABLE_DEPTH - 1);
                endcase
                n = 0;
            end else begin
                n   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 64);
                cnt = n;
            end
            write_count(cnt[CNT_W-1:0]);

            if (phase == 0) begin
                span = 64'd8388608;
                acc  = -64'sd2147483648;
            end else begin
                r = $urandom_range(0, 3);
                case (r)
                    0:       span = 3;
                    1:       span = 1000;
                    2:       span = 64'h0100_0000;
                    default: span = 64'd4294967296 / ((n > 0) ? n : 1);
                endcase
                r = $urandom_range(0, 2);
                case (r)
                    0:       acc = -64'sd2147483648;
                    1:       acc = 64'sd2147483647 - (longint'(n) * span) / 2;
                    default: acc = longint'($signed($urandom));
                endcase
            end
            for (i = 0; i < n; i++) begin
                send_word(sjs_pkg::CMD_LOAD, i[IDX_W-1:0], acc[VAL_W-1:0], 1'b0, none);
                random_words++;
                acc += (longint'($urandom) * span) >>> 32;
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            end

            live     = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
            searches = $urandom_range(8, 30);
            for (k = 0; k < searches; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_word(sjs_pkg::CMD_LOAD, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                              $urandom, 1'b0, none);
                    random_words++;
                end
                r    = $urandom_range(0, 9);
                pick = (live > 0) ? $urandom_range(0, live - 1) : 0;
                if (live == 0 || r == 8)
                    key = $urandom;
                else if (r < 6)
                    key = entries_q[pick];
                else if (r == 6)
                    key = entries_q[pick] + 32'd1;
                else if (r == 7)
                    key = entries_q[pick] - 32'd1;
                else begin
                    case ($urandom_range(0, 3))
                        0:       key = VAL_MIN;
                        1:       key = VAL_MAX;
                        2:       key = entries_q[0] - 32'd1;
                        default: key = entries_q[live - 1] + 32'd1;
                    endcase
                end
                send_word(sjs_pkg::CMD_SEARCH, IDX_W'($urandom), key, 1'b0, none);
                random_words++;
            end
        end

        idle_input();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
